@@ design/sbhc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbhc_pkg
// Shared constants, types and the byte-wide CRC-32 update for the
// superblock header checker.
// ----------------------------------------------------------------------------
package sbhc_pkg;

    // header geometry
    localparam int HeaderBytesDefault   = 36;
    localparam int SuperCrcOffset       = 32;
    localparam int SuperLogEndOffset    = 24;
    localparam int SuperGenerationOffset = 8;
    localparam int WordCount            = 9;
    localparam int WordIdxW             = $clog2(WordCount);

    // word slots in the assembled header
    localparam logic [WordIdxW-1:0] WordMagic      = WordIdxW'(0);
    localparam logic [WordIdxW-1:0] WordVersion    = WordIdxW'(1);
    localparam logic [WordIdxW-1:0] WordGeneration = WordIdxW'(SuperGenerationOffset / 4);
    localparam logic [WordIdxW-1:0] WordSectorSize = WordIdxW'(3);
    localparam logic [WordIdxW-1:0] WordContainer  = WordIdxW'(4);
    localparam logic [WordIdxW-1:0] WordLogStart   = WordIdxW'(5);
    localparam logic [WordIdxW-1:0] WordLogEnd     = WordIdxW'(SuperLogEndOffset / 4);
    localparam logic [WordIdxW-1:0] WordFlags      = WordIdxW'(7);
    localparam logic [WordIdxW-1:0] WordCrc        = WordIdxW'(SuperCrcOffset / 4);

    // crc-32, reflected form
    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgExpectedMagic   = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgExpectedVersion = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgDataStartSector = CfgIdxW'(2);

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_CRC   = 2'd1,
        STATUS_FIELD = 2'd2
    } status_t;

    typedef logic [WordCount-1:0][31:0] word_array_t;

    // a finished header handed from the accumulator to the check stage
    typedef struct packed {
        logic [31:0] crc;
        word_array_t words;
    } hdr_t;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [31:0] c;
        int          k;
        c = crc_in ^ {24'd0, data_in};
        for (k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

@@ design/sbhc_accum.sv @@
// ----------------------------------------------------------------------------
// sbhc_accum
// Byte position counter, running CRC and big-endian word assembly. Hands a
// finished header to the check stage on the last byte.
// ----------------------------------------------------------------------------
module sbhc_accum #(
    parameter int HEADER_BYTES = sbhc_pkg::HeaderBytesDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_ready,
    input  logic [7:0]        data_byte,
    output logic              hdr_valid,
    input  logic              hdr_ready,
    output sbhc_pkg::hdr_t    hdr
);
    import sbhc_pkg::*;

    localparam int PosW = $clog2(HEADER_BYTES);
    localparam logic [PosW-1:0] PosLast     = PosW'(HEADER_BYTES - 1);
    localparam logic [PosW-1:0] PosWordsEnd = PosW'(WordCount * 4);
    localparam logic [PosW-1:0] PosCrcFirst = PosW'(SuperCrcOffset);
    localparam logic [PosW-1:0] PosCrcLast  = PosW'(SuperCrcOffset + 3);

    logic [PosW-1:0]     pos_reg, pos_next;
    logic [31:0]         crc_reg, crc_next;
    word_array_t         words_reg, words_next;

    logic [7:0]          fed;
    logic [31:0]         crc_upd;
    word_array_t         words_upd;
    logic [WordIdxW-1:0] word_idx;
    logic                is_last;
    logic                accept;

    // a non-final byte always goes in; the final one waits for the check stage
    assign is_last    = (pos_reg == PosLast);
    assign data_ready = !is_last || hdr_ready;
    assign accept     = data_valid && data_ready;
    assign word_idx   = pos_reg[WordIdxW+1:2];

    // crc update, stored crc bytes enter as zero
    always_comb
    begin
        fed = data_byte;
        if (pos_reg inside {[PosCrcFirst:PosCrcLast]})
        begin
            fed = 8'd0;
        end
        crc_upd = crc32_byte(crc_reg, fed);
    end

    // shift the byte into its word
    always_comb
    begin
        words_upd = words_reg;
        if (pos_reg < PosWordsEnd)
        begin
            words_upd[word_idx] = {words_reg[word_idx][23:0], data_byte};
        end
    end

    // next state
    always_comb
    begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        words_next = words_reg;
        if (accept)
        begin
            words_next = words_upd;
            if (is_last)
            begin
                pos_next = '0;
                crc_next = CrcInit;
            end
            else
            begin
                pos_next = pos_reg + PosW'(1);
                crc_next = crc_upd;
            end
        end
    end

    // finished header
    assign hdr_valid = accept && is_last;
    assign hdr       = {~crc_upd, words_upd};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CrcInit;
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // word store, written before read
    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

endmodule

@@ design/sbhc_check.sv @@
// ----------------------------------------------------------------------------
// sbhc_check
// Holds a finished header, checks CRC and fields, and drives the result
// register with its valid/ready handshake.
// ----------------------------------------------------------------------------
module sbhc_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hdr_valid,
    output logic              hdr_ready,
    input  sbhc_pkg::hdr_t    hdr,
    input  logic [31:0]       expected_magic,
    input  logic [31:0]       expected_version,
    input  logic [31:0]       data_start_sector,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [1:0]        status,
    output logic [31:0]       generation,
    output logic [31:0]       block_bytes,
    output logic [31:0]       volume_sectors,
    output logic [31:0]       journal_first,
    output logic [31:0]       journal_last,
    output logic [31:0]       flag_word,
    output logic [31:0]       header_crc
);
    import sbhc_pkg::*;

    hdr_t        chk_reg;
    logic        chk_valid_reg, chk_valid_next;
    logic        chk_move;

    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    word_array_t fields_reg, fields_next;

    logic        crc_bad;
    logic        fields_bad;

    // handshake between the stages
    assign chk_move  = chk_valid_reg && (!out_valid_reg || result_ready);
    assign hdr_ready = !chk_valid_reg || chk_move;

    always_comb
    begin
        chk_valid_next = chk_valid_reg;
        if (hdr_valid)
        begin
            chk_valid_next = 1'b1;
        end
        else if (chk_move)
        begin
            chk_valid_next = 1'b0;
        end
    end

    // crc and field checks
    assign crc_bad = (chk_reg.crc != chk_reg.words[WordCrc]);
    assign fields_bad =
        (chk_reg.words[WordMagic]      != expected_magic) ||
        (chk_reg.words[WordVersion]    != expected_version) ||
        (chk_reg.words[WordSectorSize] == 32'd0) ||
        (chk_reg.words[WordContainer]  <  data_start_sector) ||
        (chk_reg.words[WordLogStart]   != data_start_sector) ||
        (chk_reg.words[WordLogEnd]     <  chk_reg.words[WordLogStart]) ||
        (chk_reg.words[WordLogEnd]     >  chk_reg.words[WordContainer]);

    always_comb
    begin
        if (crc_bad)
        begin
            status_next = STATUS_CRC;
        end
        else if (fields_bad)
        begin
            status_next = STATUS_FIELD;
        end
        else
        begin
            status_next = STATUS_OK;
        end
        fields_next = (status_next == STATUS_OK) ? chk_reg.words : '0;
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (chk_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (hdr_valid)
        begin
            chk_reg <= hdr;
        end
        if (chk_move)
        begin
            status_reg <= status_next;
            fields_reg <= fields_next;
        end
    end

    assign result_valid   = out_valid_reg;
    assign status         = status_reg;
    assign generation     = fields_reg[WordGeneration];
    assign block_bytes    = fields_reg[WordSectorSize];
    assign volume_sectors = fields_reg[WordContainer];
    assign journal_first  = fields_reg[WordLogStart];
    assign journal_last   = fields_reg[WordLogEnd];
    assign flag_word      = fields_reg[WordFlags];
    assign header_crc     = fields_reg[WordCrc];

endmodule

@@ design/superblock_header_checker.sv @@
// ----------------------------------------------------------------------------
// superblock_header_checker
// Takes a superblock header one byte per item, runs CRC-32 over it, assembles
// its words and gives one checked result per header.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while data_ready is high; one result per HEADER_BYTES bytes.
// Result path: the check register loads at the edge that accepts the last byte;
//   the result register loads from it once it is empty or being drained.
// Reset: rst_n asynchronous active low; clears byte position, running CRC,
//   stage valids and the configuration registers. Word store is not reset.
// ----------------------------------------------------------------------------
module superblock_header_checker #(
    parameter int HEADER_BYTES = sbhc_pkg::HeaderBytesDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbhc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         data_valid,
    output logic                         data_ready,
    input  logic [7:0]                   data_byte,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [1:0]                   status,
    output logic [31:0]                  generation,
    output logic [31:0]                  block_bytes,
    output logic [31:0]                  volume_sectors,
    output logic [31:0]                  journal_first,
    output logic [31:0]                  journal_last,
    output logic [31:0]                  flag_word,
    output logic [31:0]                  header_crc
);
    import sbhc_pkg::*;

    logic [31:0] expected_magic_reg, expected_magic_next;
    logic [31:0] expected_version_reg, expected_version_next;
    logic [31:0] data_start_sector_reg, data_start_sector_next;

    logic        hdr_valid;
    logic        hdr_ready;
    hdr_t        hdr;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        expected_magic_next    = expected_magic_reg;
        expected_version_next  = expected_version_reg;
        data_start_sector_next = data_start_sector_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CfgExpectedMagic:   expected_magic_next    = cfg_data;
                CfgExpectedVersion: expected_version_next  = cfg_data;
                CfgDataStartSector: data_start_sector_next = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_magic_reg    <= '0;
            expected_version_reg  <= '0;
            data_start_sector_reg <= '0;
        end
        else
        begin
            expected_magic_reg    <= expected_magic_next;
            expected_version_reg  <= expected_version_next;
            data_start_sector_reg <= data_start_sector_next;
        end
    end

    // byte accumulator
    sbhc_accum #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .hdr_valid  (hdr_valid),
        .hdr_ready  (hdr_ready),
        .hdr        (hdr)
    );

    // header check and result register
    sbhc_check u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .hdr_valid         (hdr_valid),
        .hdr_ready         (hdr_ready),
        .hdr               (hdr),
        .expected_magic    (expected_magic_reg),
        .expected_version  (expected_version_reg),
        .data_start_sector (data_start_sector_reg),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .status            (status),
        .generation        (generation),
        .block_bytes       (block_bytes),
        .volume_sectors    (volume_sectors),
        .journal_first     (journal_first),
        .journal_last      (journal_last),
        .flag_word         (flag_word),
        .header_crc        (header_crc)
    );

endmodule

@@ design/sbhc_checker.sv @@
// ----------------------------------------------------------------------------
// sbhc_checker
// Port-level assertions for the superblock header checker, bound to the
// top level.
// ----------------------------------------------------------------------------
module sbhc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  status,
    input logic [31:0] generation,
    input logic [31:0] block_bytes,
    input logic [31:0] volume_sectors,
    input logic [31:0] journal_first,
    input logic [31:0] journal_last,
    input logic [31:0] flag_word,
    input logic [31:0] header_crc
);
    import sbhc_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
            && $stable(header_crc) && $stable(generation))
        else $error("stalled result changed");

    // only defined status codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == STATUS_OK) || (status == STATUS_CRC)
            || (status == STATUS_FIELD))
        else $error("undefined status code");

    // failed headers give zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != STATUS_OK) |-> (generation == '0)
            && (block_bytes == '0) && (volume_sectors == '0)
            && (journal_first == '0) && (journal_last == '0)
            && (flag_word == '0) && (header_crc == '0))
        else $error("failed header carries nonzero fields");

    // a valid header obeys the field rules
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STATUS_OK) |-> (block_bytes != '0)
            && (journal_last >= journal_first)
            && (journal_last <= volume_sectors)
            && (volume_sectors >= journal_first))
        else $error("valid header breaks field rules");

endmodule

bind superblock_header_checker sbhc_checker u_sbhc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .status         (status),
    .generation     (generation),
    .block_bytes    (block_bytes),
    .volume_sectors (volume_sectors),
    .journal_first  (journal_first),
    .journal_last   (journal_last),
    .flag_word      (flag_word),
    .header_crc     (header_crc)
);

@@ tb/sv/superblock_header_checker_tb.sv @@
// ----------------------------------------------------------------------------
// superblock_header_checker_tb
// Streams superblock headers into the checker one byte per item and checks
// every verdict against a byte-level predictor of the CRC and field rules.
// Runs directed headers covering each failure rule and boundary, then random
// headers under two random register settings, with idle bursts on both sides
// and one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module superblock_header_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbhc_pkg::*;

    localparam int HdrLen        = HeaderBytesDefault;
    localparam int ResultFields  = 7;
    localparam int DrainCycles   = 8;
    localparam int HoldOffCycles = 400;
    // hold-off plus the longest idle bursts, taken several times over
    localparam int WatchdogLimit = 4000;
    localparam int RandomPhases  = 2;
    localparam int RandomHeaders = 3;

    localparam logic [31:0]         AllOnes   = 32'hFFFF_FFFF;
    localparam logic [CfgIdxW-1:0]  CfgUnused = CfgIdxW'(3);

    typedef logic [7:0] header_bytes_t [HdrLen];

    typedef enum int {
        HK_VALID,
        HK_TIGHT,
        HK_LOG_END_AT_TOP,
        HK_BAD_CRC,
        HK_CRC_AND_FIELD,
        HK_BAD_MAGIC,
        HK_BAD_VERSION,
        HK_ZERO_SECTOR,
        HK_SMALL_CONTAINER,
        HK_BAD_LOG_START,
        HK_LOG_END_LOW,
        HK_LOG_END_HIGH,
        HK_ZEROS,
        HK_ONES,
        HK_NOISE
    } header_kind_t;

    typedef struct packed {
        status_t                         status;
        logic [ResultFields-1:0][31:0]   field;
    } header_verdict_t;

    // byte-level predictor and verdict store
    class header_scoreboard_t;
        logic [31:0]     magic_reg;
        logic [31:0]     version_reg;
        logic [31:0]     start_reg;
        int              byte_pos;
        logic [31:0]     crc_acc;
        logic [31:0]     words [WordCount];
        header_verdict_t verdicts [$];
        string           field_names [ResultFields];
        int              errors;
        int              seen [3];

        function new();
            field_names = '{"generation", "block_bytes", "volume_sectors",
                            "journal_first", "journal_last", "flag_word",
                            "header_crc"};
            magic_reg   = '0;
            version_reg = '0;
            start_reg   = '0;
            byte_pos    = 0;
            crc_acc     = CrcInit;
            foreach (words[i])
                words[i] = '0;
            errors = 0;
            seen   = '{0, 0, 0};
        endfunction

        // reflected crc-32, one byte, lsb first
        static function logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
            logic [31:0] r;
            int          k;
            r = crc ^ {24'd0, b};
            for (k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
            return r;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
            case (idx)
                CfgExpectedMagic:   magic_reg   = value;
                CfgExpectedVersion: version_reg = value;
                CfgDataStartSector: start_reg   = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // one accepted header byte; the last one yields a verdict
        function void note_byte(logic [7:0] b);
            logic [7:0]      fed;
            logic [31:0]     sum;
            header_verdict_t v;
            int              idx;
            int              j;
            fed = (byte_pos >= SuperCrcOffset && byte_pos < SuperCrcOffset + 4) ? 8'h00 : b;
            crc_acc = crc32_step(crc_acc, fed);
            if (byte_pos < 4 * WordCount)
            begin
                idx = byte_pos / 4;
                words[idx] = {words[idx][23:0], b};
            end
            if (byte_pos != HdrLen - 1)
            begin
                byte_pos++;
                return;
            end
            sum      = ~crc_acc;
            byte_pos = 0;
            crc_acc  = CrcInit;
            v.field  = '0;
            if (sum != words[WordCrc])
                v.status = STATUS_CRC;
            else if (words[WordMagic] != magic_reg ||
                     words[WordVersion] != version_reg ||
                     words[WordSectorSize] == 32'd0 ||
                     words[WordContainer] < start_reg ||
                     words[WordLogStart] != start_reg ||
                     words[WordLogEnd] < words[WordLogStart] ||
                     words[WordLogEnd] > words[WordContainer])
                v.status = STATUS_FIELD;
            else
            begin
                v.status = STATUS_OK;
                for (j = 0; j < ResultFields; j++)
                    v.field[j] = words[int'(WordGeneration) + j];
            end
            verdicts.push_back(v);
        endfunction

        // one accepted result against the oldest verdict
        function void check_result(logic [1:0] st, logic [ResultFields-1:0][31:0] act);
            header_verdict_t v;
            int              j;
            if (verdicts.size() == 0)
            begin
                $display("%0t: result with no header pending, status %0d", $time, st);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            seen[int'(v.status)]++;
            if (st !== v.status)
            begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, v.status, st);
                errors++;
            end
            for (j = 0; j < ResultFields; j++)
            begin
                if (act[j] !== v.field[j])
                begin
                    $display("%0t: %s mismatch, expected %h actual %h",
                             $time, field_names[j], v.field[j], act[j]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index    = '0;
    logic [31:0]          cfg_data     = '0;
    logic                 data_valid   = 1'b0;
    logic                 data_ready;
    logic [7:0]           data_byte    = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [1:0]           status;
    logic [31:0]          generation;
    logic [31:0]          block_bytes;
    logic [31:0]          volume_sectors;
    logic [31:0]          journal_first;
    logic [31:0]          journal_last;
    logic [31:0]          flag_word;
    logic [31:0]          header_crc;

    header_scoreboard_t sb;
    bit               idle_on      = 1'b1;
    bit               hold_off_req = 1'b0;
    int               settings_used = 0;
    int               quiet_cycles  = 0;

    superblock_header_checker #(
        .HEADER_BYTES (HdrLen)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .status         (status),
        .generation     (generation),
        .block_bytes    (block_bytes),
        .volume_sectors (volume_sectors),
        .journal_first  (journal_first),
        .journal_last   (journal_last),
        .flag_word      (flag_word),
        .header_crc     (header_crc)
    );

    // 8 ns clock
    always
    begin
        #4ns clk = 1'b1;
        #4ns clk = 1'b0;
    end

    // sample handshakes at the rising edge, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (data_valid && data_ready)
                sb.note_byte(data_byte);
            if (result_valid && result_ready)
                sb.check_result(status, {header_crc, flag_word, journal_last,
                                         journal_first, volume_sectors,
                                         block_bytes, generation});
            if ((cfg_valid && cfg_ready) || (data_valid && data_ready) ||
                (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
                $display("superblock_header_checker_tb NOT OK");
                $finish;
            end
        end
    end

    // result side: random stalls and one long hold-off
    initial
    begin : result_sink
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_ready = 1'b0;
                repeat (HoldOffCycles) @(negedge clk);
                hold_off_req = 1'b0;
                result_ready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_ready = 1'b0;
                burst = $urandom_range(1, 9);
                repeat (burst) @(negedge clk);
                result_ready = 1'b1;
            end
            else
                result_ready = 1'b1;
        end
    end

    // value in [lo, hi], biased toward the ends
    function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
        logic [32:0] span;
        span = {1'b0, hi} - {1'b0, lo} + 33'd1;
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default:
            begin
                if (span[32])
                    return $urandom;
                return lo + ($urandom % span[31:0]);
            end
        endcase
    endfunction

    function automatic logic [31:0] nonzero_word();
        logic [31:0] w;
        w = $urandom;
        if (w == 32'd0)
            w = 32'd1;
        return w;
    endfunction

    // build one header of the given kind for the given register values
    function automatic header_bytes_t make_header(header_kind_t kind, logic [31:0] m,
                                                  logic [31:0] v, logic [31:0] ds);
        logic [31:0]   w [WordCount];
        header_bytes_t hdr;
        logic [31:0]   sum;
        int            i;
        w[0] = m;
        w[1] = v;
        w[2] = $urandom;
        w[3] = pick_between(32'd1, AllOnes);
        w[4] = pick_between(ds, AllOnes);
        w[5] = ds;
        w[6] = pick_between(ds, w[4]);
        w[7] = $urandom;
        w[8] = '0;
        case (kind)
            HK_TIGHT:
            begin
                w[4] = ds;
                w[6] = ds;
            end
            HK_LOG_END_AT_TOP:                w[6] = w[4];
            HK_BAD_MAGIC, HK_CRC_AND_FIELD:   w[0] = m ^ nonzero_word();
            HK_BAD_VERSION:                   w[1] = v ^ nonzero_word();
            HK_ZERO_SECTOR:                   w[3] = '0;
            HK_BAD_LOG_START:                 w[5] = ds ^ nonzero_word();
            HK_SMALL_CONTAINER:
                if (ds != 32'd0)
                    w[4] = pick_between(32'd0, ds - 32'd1);
                else
                    w[0] = m ^ nonzero_word();
            HK_LOG_END_LOW:
                if (ds != 32'd0)
                    w[6] = pick_between(32'd0, ds - 32'd1);
                else
                    w[1] = v ^ nonzero_word();
            HK_LOG_END_HIGH:
                if (ds != AllOnes)
                begin
                    w[4] = pick_between(ds, AllOnes - 32'd1);
                    w[6] = pick_between(w[4] + 32'd1, AllOnes);
                end
                else
                    w[3] = '0;
            default: ;
        endcase
        for (i = 0; i < HdrLen; i++)
        begin
            if (i < 4 * WordCount)
                hdr[i] = w[i / 4][8 * (3 - i % 4) +: 8];
            else
                hdr[i] = $urandom;
        end
        case (kind)
            HK_ZEROS:
                foreach (hdr[k])
                    hdr[k] = 8'h00;
            HK_ONES:
                foreach (hdr[k])
                    hdr[k] = 8'hFF;
            HK_NOISE:
                foreach (hdr[k])
                    hdr[k] = $urandom;
            default:
            begin
                // crc over the header with its crc word taken as zero
                sum = CrcInit;
                for (i = 0; i < HdrLen; i++)
                    sum = header_scoreboard_t::crc32_step(sum,
                        (i >= SuperCrcOffset && i < SuperCrcOffset + 4) ? 8'h00 : hdr[i]);
                sum = ~sum;
                if (kind == HK_BAD_CRC || kind == HK_CRC_AND_FIELD)
                    sum ^= 32'd1 << $urandom_range(0, 31);
                for (i = 0; i < 4; i++)
                    hdr[SuperCrcOffset + i] = sum[8 * (3 - i) +: 8];
            end
        endcase
        return hdr;
    endfunction

    function automatic header_kind_t random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return HK_VALID;
        if (r < 45)
            return HK_TIGHT;
        if (r < 50)
            return HK_LOG_END_AT_TOP;
        if (r < 72)
            return header_kind_t'($urandom_range(int'(HK_BAD_MAGIC), int'(HK_LOG_END_HIGH)));
        if (r < 82)
            return HK_BAD_CRC;
        if (r < 86)
            return HK_CRC_AND_FIELD;
        return HK_NOISE;
    endfunction

    // called at a falling edge; leaves valid high on the last byte
    task automatic send_header(header_bytes_t hdr);
        int i;
        for (i = 0; i < HdrLen; i++)
        begin
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                data_valid = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            data_valid = 1'b1;
            data_byte  = hdr[i];
            @(posedge clk);
            while (!data_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // write all registers back to back, plus the unused index
    task automatic configure(logic [31:0] m, logic [31:0] v, logic [31:0] ds);
        logic [CfgIdxW-1:0] idx [4];
        logic [31:0]        val [4];
        int                 i;
        idx = '{CfgExpectedMagic, CfgExpectedVersion, CfgDataStartSector, CfgUnused};
        val = '{m, v, ds, $urandom};
        for (i = 0; i < 4; i++)
        begin
            cfg_valid = 1'b1;
            cfg_index = idx[i];
            cfg_data  = val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_valid = 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
    endtask

    // optionally reprogram, stream the planned headers, drain
    task automatic run_phase(bit do_cfg, logic [31:0] m, logic [31:0] v, logic [31:0] ds,
                             header_kind_t plan [$]);
        int i;
        if (do_cfg)
            configure(m, v, ds);
        for (i = 0; i < plan.size(); i++)
            send_header(make_header(plan[i], m, v, ds));
        data_valid = 1'b0;
        wait_idle();
    endtask

    // main sequence
    initial
    begin : stimulus
        header_kind_t plan [$];
        logic [31:0]  m;
        logic [31:0]  v;
        logic [31:0]  ds;
        int           p;
        int           i;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // registers at their reset values
        plan = '{HK_VALID, HK_BAD_MAGIC};
        run_phase(1'b0, 32'd0, 32'd0, 32'd0, plan);

        // every rule and boundary under typical registers
        plan = '{HK_VALID, HK_TIGHT, HK_LOG_END_AT_TOP, HK_BAD_CRC, HK_CRC_AND_FIELD,
                 HK_BAD_MAGIC, HK_BAD_VERSION, HK_ZERO_SECTOR, HK_SMALL_CONTAINER,
                 HK_BAD_LOG_START, HK_LOG_END_LOW, HK_LOG_END_HIGH, HK_ZEROS, HK_ONES,
                 HK_NOISE};
        run_phase(1'b1, 32'h5342_4844, 32'h0001_0002, 32'h0000_0800, plan);

        // registers at all ones
        plan = '{HK_VALID, HK_TIGHT, HK_LOG_END_LOW, HK_SMALL_CONTAINER, HK_LOG_END_HIGH,
                 HK_ONES};
        run_phase(1'b1, AllOnes, AllOnes, AllOnes, plan);

        // registers at zero
        plan = '{HK_VALID, HK_LOG_END_AT_TOP, HK_SMALL_CONTAINER, HK_LOG_END_LOW, HK_ZEROS};
        run_phase(1'b1, 32'd0, 32'd0, 32'd0, plan);

        // random headers under random registers
        for (p = 0; p < RandomPhases; p++)
        begin
            m = $urandom;
            v = $urandom;
            case ($urandom_range(0, 3))
                0:       ds = 32'd0;
                1:       ds = $urandom_range(1, 4096);
                2:       ds = AllOnes - $urandom_range(0, 15);
                default: ds = $urandom;
            endcase
            plan.delete();
            for (i = 0; i < RandomHeaders; i++)
                plan.push_back(random_kind());
            if (p == 0)
                hold_off_req = 1'b1;
            if (p == RandomPhases - 1)
                idle_on = 1'b0;
            run_phase(1'b1, m, v, ds, plan);
        end

        $display("%0d headers over %0d register settings: %0d valid, %0d crc errors,",
                 sb.seen[0] + sb.seen[1] + sb.seen[2], settings_used,
                 sb.seen[0], sb.seen[1]);
        $display("%0d field errors; output held off once for %0d cycles",
                 sb.seen[2], HoldOffCycles);
        if (sb.errors == 0)
            $display("superblock_header_checker_tb OK");
        else
            $display("superblock_header_checker_tb NOT OK");
        $finish;
    end

endmodule
